>>> src/assert_macros.svh
// assertion macros used by the checker file nsmd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NSMD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define NSMD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/nsmd_pkg.sv
// ----------------------------------------------------------------------------
// nsmd_pkg
// shared widths, codes and fixed-point helpers of the neumann series detector
// ----------------------------------------------------------------------------
package nsmd_pkg;

  localparam int ROWS_DEF       = 256;
  localparam int COLUMNS_DEF    = 16;
  localparam int ITERATIONS_DEF = 3;

  localparam int SAMPLE_W = 24;
  localparam int ROW_W    = 8;
  localparam int COL_W    = 4;
  localparam int MODE_W   = 2;
  localparam int REG_W    = 23;
  localparam int IDX_W    = 4;
  localparam int OPB_W    = 32;
  localparam int PROD_W   = 56;
  localparam int ACC_W    = 64;
  localparam int T_W      = 40;

  localparam logic [REG_W-1:0] REG_RESET = 23'd66790;

  localparam logic [MODE_W-1:0] MODE_CHANNEL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECEIVED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIAGONAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_START    = 2'd3;

  localparam logic [1:0] PASS_MF  = 2'd0;
  localparam logic [1:0] PASS_HX  = 2'd1;
  localparam logic [1:0] PASS_HTD = 2'd2;

  localparam logic [3:0] STEP_NONE  = 4'd0;
  localparam logic [3:0] STEP_CLR   = 4'd1;
  localparam logic [3:0] STEP_RND   = 4'd2;
  localparam logic [3:0] STEP_MULD  = 4'd3;
  localparam logic [3:0] STEP_SEED  = 4'd4;
  localparam logic [3:0] STEP_MULA  = 4'd5;
  localparam logic [3:0] STEP_SETAD = 4'd6;
  localparam logic [3:0] STEP_T3    = 4'd7;
  localparam logic [3:0] STEP_T2    = 4'd8;
  localparam logic [3:0] STEP_UPD   = 4'd9;
  localparam logic [3:0] STEP_SHIFT = 4'd10;

  localparam logic signed [ACC_W-1:0] ACC_HI = 64'sh4000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_LO = 64'shC000_0000_0000_0000;

  typedef struct packed {
    logic [1:0] pass;
    logic [3:0] step;
  } ctl_t;

  function automatic logic signed [ACC_W-1:0] acc_add(logic signed [ACC_W-1:0] a,
                                                      logic signed [PROD_W-1:0] p);
    logic signed [ACC_W-1:0] s;
    s = a + {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    if (s > ACC_HI) begin
      s = ACC_HI;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
    end
    return s;
  endfunction

  function automatic logic signed [T_W-1:0] round_prod(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] w;
    w = p + 56'sd262144;
    return T_W'(w >>> 19);
  endfunction

  function automatic logic signed [OPB_W-1:0] acc_round32(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] w;
    logic signed [ACC_W-1:0] r;
    w = a + 64'sd262144;
    r = w >>> 19;
    if (r > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (r < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return r[OPB_W-1:0];
  endfunction

  function automatic logic signed [OPB_W-1:0] sat32(logic signed [T_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[OPB_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(logic signed [T_W-1:0] v);
    if (v > 40'sd8388607) begin
      return 24'sh7F_FFFF;
    end else if (v < -40'sd8388608) begin
      return 24'sh80_0000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

>>> src/nsmd_ifs.sv
// ----------------------------------------------------------------------------
// nsmd channel interfaces
// valid/ready channels for load/start items, estimates and the register write
// ----------------------------------------------------------------------------
interface nsmd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [nsmd_pkg::MODE_W-1:0]          mode;
  logic [nsmd_pkg::ROW_W-1:0]           row;
  logic [nsmd_pkg::COL_W-1:0]           column;
  logic signed [nsmd_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, mode, row, column, sample, input ready);
  modport sink (input valid, mode, row, column, sample, output ready);
endinterface

interface nsmd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [nsmd_pkg::IDX_W-1:0]           estimate_index;
  logic signed [nsmd_pkg::SAMPLE_W-1:0] estimate;
  logic                                 last;
  modport source (output valid, estimate_index, estimate, last, input ready);
  modport sink (input valid, estimate_index, estimate, last, output ready);
endinterface

interface nsmd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nsmd_pkg::REG_W-1:0]       data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> src/nsmd_ram.sv
// ----------------------------------------------------------------------------
// nsmd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module nsmd_ram #(
  parameter int WIDTH = nsmd_pkg::SAMPLE_W,
  parameter int DEPTH = nsmd_pkg::ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/nsmd_cell.sv
// ----------------------------------------------------------------------------
// nsmd_cell
// one column cell: channel column memory, multiply, saturating accumulate
// ----------------------------------------------------------------------------
module nsmd_cell #(
  parameter int ROWS = nsmd_pkg::ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nsmd_pkg::ctl_t                       ctl,
  input  logic [nsmd_pkg::REG_W-1:0]           regularization,
  input  logic                                 load_we,
  input  logic [$clog2(ROWS)-1:0]              load_addr,
  input  logic signed [nsmd_pkg::SAMPLE_W-1:0] load_data,
  input  logic                                 diag_we,
  input  logic                                 tin_valid,
  input  logic                                 tin_last,
  input  logic [$clog2(ROWS)-1:0]              tin_row,
  input  logic signed [nsmd_pkg::OPB_W-1:0]    tin_b,
  input  logic signed [nsmd_pkg::ACC_W-1:0]    tin_psum,
  output logic                                 tout_valid_r,
  output logic                                 tout_last_r,
  output logic [$clog2(ROWS)-1:0]              tout_row_r,
  output logic signed [nsmd_pkg::OPB_W-1:0]    tout_b_r,
  output logic signed [nsmd_pkg::ACC_W-1:0]    tout_psum_r,
  input  logic signed [nsmd_pkg::SAMPLE_W-1:0] x_in,
  output logic signed [nsmd_pkg::SAMPLE_W-1:0] x_out
);

  localparam int AW = $clog2(ROWS);

  logic signed [nsmd_pkg::SAMPLE_W-1:0] h_rdata;
  logic                                 s1_valid_r, s1_last_r;
  logic [AW-1:0]                        s1_row_r;
  logic signed [nsmd_pkg::OPB_W-1:0]    s1_b_r;
  logic signed [nsmd_pkg::ACC_W-1:0]    s1_psum_r;
  logic                                 s2_valid_r, s2_last_r;
  logic [AW-1:0]                        s2_row_r;
  logic signed [nsmd_pkg::OPB_W-1:0]    s2_b_r;
  logic signed [nsmd_pkg::ACC_W-1:0]    s2_psum_r;
  logic signed [nsmd_pkg::PROD_W-1:0]   prod_r;
  logic signed [nsmd_pkg::ACC_W-1:0]    acc_r;
  logic signed [nsmd_pkg::OPB_W-1:0]    rnd_r;
  logic signed [nsmd_pkg::OPB_W-1:0]    ad_r;
  logic signed [nsmd_pkg::T_W-1:0]      t1_r, t3_r, s_r;
  logic signed [nsmd_pkg::SAMPLE_W-1:0] diag_r, x_r;

  logic signed [nsmd_pkg::SAMPLE_W-1:0] mul_a;
  logic signed [nsmd_pkg::OPB_W-1:0]    mul_b;
  logic signed [nsmd_pkg::PROD_W-1:0]   mul_p;
  logic                                 prod_we;
  logic                                 is_hx;
  logic signed [nsmd_pkg::ACC_W-1:0]    sum_nxt;

  nsmd_ram #(
    .WIDTH(nsmd_pkg::SAMPLE_W),
    .DEPTH(ROWS)
  ) u_h_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(load_data),
    .raddr(tin_row),
    .rdata(h_rdata)
  );

  assign is_hx = (ctl.pass == nsmd_pkg::PASS_HX);

  always_comb begin
    unique case (ctl.step)
      nsmd_pkg::STEP_MULD: begin
        mul_a = diag_r;
        mul_b = rnd_r;
      end
      nsmd_pkg::STEP_MULA: begin
        mul_a = diag_r;
        mul_b = signed'({{(nsmd_pkg::OPB_W-nsmd_pkg::REG_W){1'b0}}, regularization});
      end
      nsmd_pkg::STEP_T3: begin
        mul_a = x_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = h_rdata;
        mul_b = is_hx ? {{(nsmd_pkg::OPB_W-nsmd_pkg::SAMPLE_W){x_r[nsmd_pkg::SAMPLE_W-1]}}, x_r}
                      : s1_b_r;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_we = s1_valid_r || (ctl.step == nsmd_pkg::STEP_MULD) ||
                   (ctl.step == nsmd_pkg::STEP_MULA) || (ctl.step == nsmd_pkg::STEP_T3);
  assign sum_nxt = nsmd_pkg::acc_add(is_hx ? s2_psum_r : acc_r, prod_r);
  assign x_out   = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      tout_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= tin_valid;
      s2_valid_r   <= s1_valid_r;
      tout_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r   <= tin_last;
    s1_row_r    <= tin_row;
    s1_b_r      <= tin_b;
    s1_psum_r   <= tin_psum;
    s2_last_r   <= s1_last_r;
    s2_row_r    <= s1_row_r;
    s2_b_r      <= s1_b_r;
    s2_psum_r   <= s1_psum_r;
    tout_last_r <= s2_last_r;
    tout_row_r  <= s2_row_r;
    tout_b_r    <= s2_b_r;
    tout_psum_r <= (s2_valid_r && is_hx) ? sum_nxt : s2_psum_r;
    if (prod_we) begin
      prod_r <= mul_p;
    end
    if (diag_we) begin
      diag_r <= load_data;
    end
    if (s2_valid_r && !is_hx) begin
      acc_r <= sum_nxt;
    end
    unique case (ctl.step)
      nsmd_pkg::STEP_CLR:   acc_r <= '0;
      nsmd_pkg::STEP_RND:   rnd_r <= nsmd_pkg::acc_round32(acc_r);
      nsmd_pkg::STEP_SEED: begin
        t1_r <= nsmd_pkg::round_prod(prod_r);
        x_r  <= nsmd_pkg::sat24(nsmd_pkg::round_prod(prod_r));
      end
      nsmd_pkg::STEP_SETAD: ad_r <= nsmd_pkg::sat32(nsmd_pkg::round_prod(prod_r));
      nsmd_pkg::STEP_T3:    t3_r <= nsmd_pkg::round_prod(prod_r);
      nsmd_pkg::STEP_T2:    s_r  <= nsmd_pkg::round_prod(prod_r) + t3_r;
      nsmd_pkg::STEP_UPD:
        x_r <= nsmd_pkg::sat24(t1_r + {{(nsmd_pkg::T_W-nsmd_pkg::SAMPLE_W){x_r[nsmd_pkg::SAMPLE_W-1]}},
                                       x_r} - s_r);
      nsmd_pkg::STEP_SHIFT: x_r <= x_in;
      default: ;
    endcase
  end

endmodule

>>> src/neumann_series_mimo_detector_core.sv
// ----------------------------------------------------------------------------
// neumann_series_mimo_detector_core
// neumann series mmse detector built as a chain of column cells
// ----------------------------------------------------------------------------
// in_ch: load transactions (mode 0 channel entry, 1 received entry, 2 diagonal
//   entry) are taken one per cycle while idle; a start (mode 3) runs a detection
// out_ch: COLUMNS estimate transactions in index order, last flags the final one
// cfg_ch: regularization write, always ready; used only while idle, user-enforced
// one pass streams ROWS rows into the cell chain, then drains the chain
// a run has 2*ITERATIONS-1 passes plus a clear state and post states P0 to P4
//   per seed or update, then the estimates leave through out_ch
// the defaults are 256 rows, 16 columns and 3 iterations
// in_ch.ready is low from a start until the last estimate is taken
// estimates leave through the chain one per cycle while out_ch.ready is high;
//   a stall holds the current estimate
// synchronous reset clears control state and sets regularization to 66790;
//   stores hold garbage until loaded
// ----------------------------------------------------------------------------
module neumann_series_mimo_detector_core #(
  parameter int ROWS       = nsmd_pkg::ROWS_DEF,
  parameter int COLUMNS    = nsmd_pkg::COLUMNS_DEF,
  parameter int ITERATIONS = nsmd_pkg::ITERATIONS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  nsmd_in_if.sink   in_ch,
  nsmd_out_if.source out_ch,
  nsmd_cfg_if.sink  cfg_ch
);

  localparam int AW   = $clog2(ROWS);
  localparam int CMAX = (ROWS > COLUMNS) ? ROWS : COLUMNS;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int ITW  = $clog2(ITERATIONS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_FEED  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_P0    = 4'd4;
  localparam logic [3:0] S_P1    = 4'd5;
  localparam logic [3:0] S_P2    = 4'd6;
  localparam logic [3:0] S_P3    = 4'd7;
  localparam logic [3:0] S_P4    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 pass_r, pass_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [ITW-1:0]             it_r, it_nxt, it_inc;
  logic [nsmd_pkg::REG_W-1:0] reg_r;
  logic                       feed_valid_r, feed_valid_nxt;
  logic                       feed_last_r, feed_last_nxt;
  logic [AW-1:0]              feed_row_r;

  logic                       in_acc, out_acc, row_ok, mf_pass;
  logic [AW-1:0]              load_addr;
  nsmd_pkg::ctl_t             ctl;

  logic signed [nsmd_pkg::SAMPLE_W-1:0] recv_rdata;
  logic signed [nsmd_pkg::OPB_W-1:0]    prod_rdata;

  logic                                 tok_valid [COLUMNS+1];
  logic                                 tok_last  [COLUMNS+1];
  logic [AW-1:0]                        tok_row   [COLUMNS+1];
  logic signed [nsmd_pkg::OPB_W-1:0]    tok_b     [COLUMNS+1];
  logic signed [nsmd_pkg::ACC_W-1:0]    tok_psum  [COLUMNS+1];
  logic signed [nsmd_pkg::SAMPLE_W-1:0] x_val     [COLUMNS];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign row_ok  = (int'(in_ch.row) < ROWS);
  assign load_addr = AW'(in_ch.row);
  assign mf_pass = (pass_r == nsmd_pkg::PASS_MF);

  always_comb begin
    ctl.pass = pass_r;
    unique case (state_r)
      S_CLR:   ctl.step = nsmd_pkg::STEP_CLR;
      S_P0:    ctl.step = nsmd_pkg::STEP_RND;
      S_P1:    ctl.step = nsmd_pkg::STEP_MULD;
      S_P2:    ctl.step = mf_pass ? nsmd_pkg::STEP_SEED : nsmd_pkg::STEP_T3;
      S_P3:    ctl.step = mf_pass ? nsmd_pkg::STEP_MULA : nsmd_pkg::STEP_T2;
      S_P4:    ctl.step = mf_pass ? nsmd_pkg::STEP_SETAD : nsmd_pkg::STEP_UPD;
      S_OUT:   ctl.step = out_acc ? nsmd_pkg::STEP_SHIFT : nsmd_pkg::STEP_NONE;
      default: ctl.step = nsmd_pkg::STEP_NONE;
    endcase
  end

  nsmd_ram #(
    .WIDTH(nsmd_pkg::SAMPLE_W),
    .DEPTH(ROWS)
  ) u_recv_ram (
    .clk  (clk),
    .we   (in_acc && (in_ch.mode == nsmd_pkg::MODE_RECEIVED) && row_ok),
    .waddr(load_addr),
    .wdata(in_ch.sample),
    .raddr(cnt_r[AW-1:0]),
    .rdata(recv_rdata)
  );

  nsmd_ram #(
    .WIDTH(nsmd_pkg::OPB_W),
    .DEPTH(ROWS)
  ) u_prod_ram (
    .clk  (clk),
    .we   (tok_valid[COLUMNS] && (pass_r == nsmd_pkg::PASS_HX)),
    .waddr(tok_row[COLUMNS]),
    .wdata(nsmd_pkg::acc_round32(tok_psum[COLUMNS])),
    .raddr(cnt_r[AW-1:0]),
    .rdata(prod_rdata)
  );

  assign tok_valid[0] = feed_valid_r;
  assign tok_last[0]  = feed_last_r;
  assign tok_row[0]   = feed_row_r;
  assign tok_b[0]     = mf_pass ? {{(nsmd_pkg::OPB_W-nsmd_pkg::SAMPLE_W){recv_rdata[nsmd_pkg::SAMPLE_W-1]}},
                                   recv_rdata} : prod_rdata;
  assign tok_psum[0]  = '0;

  for (genvar c = 0; c < COLUMNS; c++) begin : g_cell
    logic signed [nsmd_pkg::SAMPLE_W-1:0] x_next;
    if (c == COLUMNS - 1) begin : g_tail
      assign x_next = '0;
    end else begin : g_mid
      assign x_next = x_val[c+1];
    end
    nsmd_cell #(
      .ROWS(ROWS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .regularization(reg_r),
      .load_we       (in_acc && (in_ch.mode == nsmd_pkg::MODE_CHANNEL) && row_ok &&
                      (int'(in_ch.column) == c)),
      .load_addr     (load_addr),
      .load_data     (in_ch.sample),
      .diag_we       (in_acc && (in_ch.mode == nsmd_pkg::MODE_DIAGONAL) &&
                      (int'(in_ch.column) == c)),
      .tin_valid     (tok_valid[c]),
      .tin_last      (tok_last[c]),
      .tin_row       (tok_row[c]),
      .tin_b         (tok_b[c]),
      .tin_psum      (tok_psum[c]),
      .tout_valid_r  (tok_valid[c+1]),
      .tout_last_r   (tok_last[c+1]),
      .tout_row_r    (tok_row[c+1]),
      .tout_b_r      (tok_b[c+1]),
      .tout_psum_r   (tok_psum[c+1]),
      .x_in          (x_next),
      .x_out         (x_val[c])
    );
  end

  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.estimate       = x_val[0];
  assign out_ch.estimate_index = nsmd_pkg::IDX_W'(cnt_r);
  assign out_ch.last           = (cnt_r == CW'(COLUMNS - 1));

  assign it_inc = (pass_r == nsmd_pkg::PASS_HTD) ? it_r + ITW'(1) : it_r;

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    cnt_nxt        = cnt_r;
    it_nxt         = it_r;
    feed_valid_nxt = 1'b0;
    feed_last_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.mode == nsmd_pkg::MODE_START)) begin
          pass_nxt  = nsmd_pkg::PASS_MF;
          it_nxt    = '0;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cnt_nxt   = '0;
        state_nxt = S_FEED;
      end
      S_FEED: begin
        feed_valid_nxt = 1'b1;
        feed_last_nxt  = (cnt_r == CW'(ROWS - 1));
        cnt_nxt        = cnt_r + CW'(1);
        if (feed_last_nxt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (tok_valid[COLUMNS] && tok_last[COLUMNS]) begin
          if (pass_r == nsmd_pkg::PASS_HX) begin
            pass_nxt  = nsmd_pkg::PASS_HTD;
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_P0;
          end
        end
      end
      S_P0: state_nxt = S_P1;
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = S_P3;
      S_P3: state_nxt = S_P4;
      S_P4: begin
        it_nxt  = it_inc;
        cnt_nxt = '0;
        if (int'(it_inc) < ITERATIONS - 1) begin
          pass_nxt  = nsmd_pkg::PASS_HX;
          state_nxt = S_FEED;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + CW'(1);
          if (out_ch.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pass_r       <= nsmd_pkg::PASS_MF;
      cnt_r        <= '0;
      it_r         <= '0;
      feed_valid_r <= 1'b0;
      feed_last_r  <= 1'b0;
      reg_r        <= nsmd_pkg::REG_RESET;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      cnt_r        <= cnt_nxt;
      it_r         <= it_nxt;
      feed_valid_r <= feed_valid_nxt;
      feed_last_r  <= feed_last_nxt;
      if (cfg_ch.valid) begin
        reg_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    feed_row_r <= cnt_r[AW-1:0];
  end

endmodule

>>> src/nsmd_checker.sv
// ----------------------------------------------------------------------------
// nsmd_checker
// port-level checks of the detector result sequence
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsmd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [nsmd_pkg::IDX_W-1:0]           out_index,
  input logic signed [nsmd_pkg::SAMPLE_W-1:0] out_estimate,
  input logic                                 out_last
);

  // stalled transaction holds
  `NSMD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_estimate) && $stable(out_index) && $stable(out_last))

  // no new item taken while estimates are pending
  `NSMD_ASSERT_IMP(a_busy_out, out_valid, !in_ready)

  // estimates come back to back in index order
  `NSMD_ASSERT_NXT(a_out_order, out_valid && out_ready && !out_last, out_valid && out_index == $past(out_index) + 4'd1)

  // run ends after the last estimate
  `NSMD_ASSERT_NXT(a_out_end, out_valid && out_ready && out_last, !out_valid && in_ready)

endmodule

bind neumann_series_mimo_detector_core nsmd_checker u_nsmd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_index   (out_ch.estimate_index),
  .out_estimate(out_ch.estimate),
  .out_last    (out_ch.last)
);
